>>> src/cplpm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the checkpoint lattice path power block.
// Used by the top level and the testbench; depends on nothing else.
package cplpm_pkg;

  // Fixed field widths of the request and result.
  localparam int FIELD_W  = 11;
  localparam int EXP_W    = 63;
  localparam int ANSWER_W = 30;

  // Prime modulus of the path counts and the power; answers fit in ANSWER_W bits.
  localparam int MODULUS = 1000000007;

  // One request: grid size, checkpoint and exponent.
  typedef struct packed {
    logic [FIELD_W-1:0] grid_rows;
    logic [FIELD_W-1:0] grid_cols;
    logic [FIELD_W-1:0] check_row;
    logic [FIELD_W-1:0] check_col;
    logic [EXP_W-1:0]   exponent;
  } req_t;

  // One result.
  typedef struct packed {
    logic [ANSWER_W-1:0] answer;
    logic                bad_request;
  } rsp_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_CELL,
    ST_PROD,
    ST_PROD_WAIT,
    ST_EXP,
    ST_ACC_WAIT,
    ST_SQ_WAIT,
    ST_FINISH
  } state_t;

endpackage

>>> src/cplpm_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing else.
module cplpm_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/cplpm_mulmod.sv
`timescale 1ns / 1ps
// Bit-serial modular multiplier: one bit of the first operand per cycle.
// Depends on nothing else; no submodules.
module cplpm_mulmod #(
  parameter int MODULUS = 1000000007
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [$clog2(MODULUS)-1:0]   a,
  input  logic [$clog2(MODULUS)-1:0]   b,
  output logic                         done,
  output logic [$clog2(MODULUS)-1:0]   product
);

  localparam int RES_W = $clog2(MODULUS);
  localparam int CNT_W = $clog2(RES_W + 1);
  localparam logic [RES_W+1:0] MOD1 = (RES_W+2)'(MODULUS);
  localparam logic [RES_W+1:0] MOD2 = MOD1 << 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [RES_W-1:0] mult;
  logic [RES_W-1:0] addend;
  logic [RES_W-1:0] acc;
  logic [RES_W+1:0] step_raw;
  logic [RES_W-1:0] step_red;

  // One step: acc = 2*acc + bit*b, brought back below the modulus.
  always_comb begin
    step_raw = {1'b0, acc, 1'b0} + {2'b00, (mult[RES_W-1] ? addend : '0)};
    if (step_raw >= MOD2) begin
      step_red = RES_W'(step_raw - MOD2);
    end else if (step_raw >= MOD1) begin
      step_red = RES_W'(step_raw - MOD1);
    end else begin
      step_red = RES_W'(step_raw);
    end
  end

  // Control: busy while the RES_W steps run, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mult   <= a;
      addend <= b;
      cnt    <= CNT_W'(RES_W);
    end else if (busy) begin
      acc  <= step_red;
      mult <= mult << 1;
      cnt  <= cnt - CNT_W'(1);
    end
  end

  assign product = acc;

  // A new product is never started while one is in progress.
  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("mulmod started while busy");

  // The finished product is a proper residue.
  assert property (@(posedge clk) disable iff (rst) done |-> ({2'b00, acc} < MOD1))
    else $error("mulmod result not reduced");

  // The last step is always followed by done.
  assert property (@(posedge clk) disable iff (rst)
                   (busy && !start && cnt == CNT_W'(1)) |=> done)
    else $error("mulmod missed done");

endmodule

>>> src/checkpoint_lattice_path_power_mod_unit.sv
`timescale 1ns / 1ps
// A rejected request goes straight to the finish state and into the result register.
// A valid request counts both path blocks through the row buffer RAM, row by row (a block
// that is one row or one column wide takes a single pass over its columns), then forms
// the product of the two counts and raises it to the exponent by square-and-multiply.
// One request at a time; the next is taken once the result is registered.
// Reset is synchronous; it idles the sequencer and empties the result register.
module checkpoint_lattice_path_power_mod_unit
  import cplpm_pkg::*;
#(
  parameter int MAX_DIM = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int ADDR_W = $clog2(MAX_DIM);
  localparam int DIM_W  = $clog2(MAX_DIM + 1);
  localparam int RES_W  = $clog2(MODULUS);
  localparam logic [RES_W:0]   MOD_W   = (RES_W+1)'(MODULUS);
  localparam logic [RES_W-1:0] RES_ONE = RES_W'(1);

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0] col;
  logic [DIM_W-1:0]  row_idx;
  logic [DIM_W-1:0]  cur_rows;
  logic [DIM_W-1:0]  cur_cols;
  logic [DIM_W-1:0]  sec_rows;
  logic [DIM_W-1:0]  sec_cols;
  logic              phase;
  logic              bad;
  logic [RES_W-1:0]  left;
  logic [RES_W-1:0]  first_count;
  logic [RES_W-1:0]  second_count;
  logic [RES_W-1:0]  power_acc;
  logic [RES_W-1:0]  power_base;
  logic [EXP_W-1:0]  exponent_left;

  logic              req_bad;
  logic              col_last;
  logic              row_last;
  logic              short_grid;
  logic              phase_end;
  logic [RES_W-1:0]  end_count;
  logic [RES_W:0]    sum_raw;
  logic [RES_W-1:0]  sum_mod;
  logic              rsp_load;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [RES_W-1:0]  mem_wr_data;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic [RES_W-1:0]  mem_rd_data;

  logic              mm_start;
  logic [RES_W-1:0]  mm_a;
  logic [RES_W-1:0]  mm_b;
  logic              mm_done;
  logic [RES_W-1:0]  mm_product;

  // Row buffer for the path count recurrence.
  cplpm_ram #(
    .WIDTH (RES_W),
    .DEPTH (MAX_DIM)
  ) u_row_store (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // Shared modular multiplier for the product and the exponentiation.
  cplpm_mulmod #(
    .MODULUS (MODULUS)
  ) u_mulmod (
    .clk     (clk),
    .rst     (rst),
    .start   (mm_start),
    .a       (mm_a),
    .b       (mm_b),
    .done    (mm_done),
    .product (mm_product)
  );

  // Request check: grid size in range and checkpoint inside the grid.
  assign req_bad = (req.grid_rows == '0) || (req.grid_cols == '0) ||
                   (32'(req.grid_rows) > 32'(MAX_DIM)) ||
                   (32'(req.grid_cols) > 32'(MAX_DIM)) ||
                   (req.check_row == '0) || (req.check_col == '0) ||
                   (req.check_row > req.grid_rows) ||
                   (req.check_col > req.grid_cols);

  // Position in the current grid pass.
  assign col_last   = (DIM_W'(col) == cur_cols - DIM_W'(1));
  assign row_last   = (row_idx == cur_rows - DIM_W'(1));
  assign short_grid = (cur_rows == DIM_W'(1)) || (cur_cols == DIM_W'(1));

  // Cell update: value above plus value to the left, modulo the prime.
  always_comb begin
    sum_raw = {1'b0, mem_rd_data} + {1'b0, left};
    if (sum_raw >= MOD_W) begin
      sum_mod = RES_W'(sum_raw - MOD_W);
    end else begin
      sum_mod = RES_W'(sum_raw);
    end
  end

  // End of a path count pass and the count it leaves.
  assign phase_end = (state == ST_INIT && col_last && short_grid) ||
                     (state == ST_CELL && col_last && row_last);
  assign end_count = (state == ST_INIT) ? RES_ONE : sum_mod;

  assign rsp_load = (state == ST_FINISH) && (!rsp_valid || !rsp_stall);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = req_bad ? ST_FINISH : ST_INIT;
        end
      end
      ST_INIT: begin
        if (col_last) begin
          if (short_grid) begin
            state_next = phase ? ST_PROD : ST_INIT;
          end else begin
            state_next = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        state_next = ST_CELL;
      end
      ST_CELL: begin
        if (col_last) begin
          if (row_last) begin
            state_next = phase ? ST_PROD : ST_INIT;
          end else begin
            state_next = ST_ROW;
          end
        end
      end
      ST_PROD: begin
        state_next = ST_PROD_WAIT;
      end
      ST_PROD_WAIT: begin
        if (mm_done) begin
          state_next = ST_EXP;
        end
      end
      ST_EXP: begin
        if (exponent_left == '0) begin
          state_next = ST_FINISH;
        end else if (exponent_left[0]) begin
          state_next = ST_ACC_WAIT;
        end else begin
          state_next = ST_SQ_WAIT;
        end
      end
      ST_ACC_WAIT: begin
        if (mm_done) begin
          state_next = ST_SQ_WAIT;
        end
      end
      ST_SQ_WAIT: begin
        if (mm_done) begin
          state_next = ST_EXP;
        end
      end
      ST_FINISH: begin
        if (rsp_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Memory port, multiplier control and handshake outputs.
  always_comb begin
    req_stall   = (state != ST_IDLE);
    mem_we      = (state == ST_INIT) || (state == ST_CELL);
    mem_wr_addr = col;
    mem_wr_data = (state == ST_INIT) ? RES_ONE : sum_mod;
    mem_rd_addr = (state == ST_ROW) ? ADDR_W'(1) : col + ADDR_W'(1);
    mm_start    = 1'b0;
    mm_a        = power_base;
    mm_b        = power_base;
    case (state)
      ST_PROD: begin
        mm_start = 1'b1;
        mm_a     = first_count;
        mm_b     = second_count;
      end
      ST_EXP: begin
        mm_start = (exponent_left != '0);
        if (exponent_left[0]) begin
          mm_a = power_acc;
        end
      end
      ST_ACC_WAIT: begin
        mm_start = mm_done;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          bad           <= req_bad;
          cur_rows      <= DIM_W'(req.check_row);
          cur_cols      <= DIM_W'(req.check_col);
          sec_rows      <= DIM_W'(req.grid_rows - req.check_row + FIELD_W'(1));
          sec_cols      <= DIM_W'(req.grid_cols - req.check_col + FIELD_W'(1));
          exponent_left <= req.exponent;
          phase         <= 1'b0;
          col           <= '0;
          power_acc     <= RES_ONE;
        end
      end
      ST_INIT: begin
        if (col_last) begin
          row_idx <= DIM_W'(1);
        end else begin
          col <= col + ADDR_W'(1);
        end
      end
      ST_ROW: begin
        col  <= ADDR_W'(1);
        left <= RES_ONE;
      end
      ST_CELL: begin
        left <= sum_mod;
        if (!col_last) begin
          col <= col + ADDR_W'(1);
        end else if (!row_last) begin
          row_idx <= row_idx + DIM_W'(1);
        end
      end
      ST_PROD_WAIT: begin
        if (mm_done) begin
          power_base <= mm_product;
        end
      end
      ST_ACC_WAIT: begin
        if (mm_done) begin
          power_acc <= mm_product;
        end
      end
      ST_SQ_WAIT: begin
        if (mm_done) begin
          power_base    <= mm_product;
          exponent_left <= exponent_left >> 1;
        end
      end
      default: begin
      end
    endcase

    // Close a path count pass: keep its count and set up the second pass.
    if (phase_end) begin
      if (!phase) begin
        first_count <= end_count;
        phase       <= 1'b1;
        cur_rows    <= sec_rows;
        cur_cols    <= sec_cols;
        col         <= '0;
      end else begin
        second_count <= end_count;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.answer      <= bad ? '0 : ANSWER_W'(power_acc);
      rsp.bad_request <= bad;
    end
  end

  // A rejected request always carries a zero answer.
  assert property (@(posedge clk) disable iff (rst)
                   (rsp_valid && rsp.bad_request) |-> (rsp.answer == '0))
    else $error("bad request with nonzero answer");

  // Within a row the look-ahead read never hits the cell being written.
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_CELL && !col_last) |-> (mem_rd_addr != mem_wr_addr))
    else $error("row buffer read and write collide");

  // The column index stays inside the current grid.
  assert property (@(posedge clk) disable iff (rst)
                   (state == ST_CELL || state == ST_INIT) |-> (DIM_W'(col) < cur_cols))
    else $error("column index past grid edge");

  // An accepted request always starts work.
  assert property (@(posedge clk) disable iff (rst)
                   (req_valid && !req_stall) |=> (state != ST_IDLE))
    else $error("accepted request dropped");

endmodule

>>> dv/checkpoint_lattice_path_power_mod_unit_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for checkpoint_lattice_path_power_mod_unit.
// Depends on cplpm_pkg for the request and result types and on the unit and its submodules.
module checkpoint_lattice_path_power_mod_unit_test;
  import cplpm_pkg::*;

  localparam longint unsigned PRIME = 64'(MODULUS);
  localparam int unsigned GRID_MAX = 1024;
  localparam logic [EXP_W-1:0] EXP_MAX = '1;
  localparam int unsigned STALL_LIMIT = 8000000;
  localparam int unsigned DRAIN_CYCLES = 40;

  // One directed row: the request and, where it is obvious, the answer.
  typedef struct {
    req_t stim;
    bit   typed;
    rsp_t want;
  } path_case_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  rsp_t            pending_answers[$];
  path_case_t      directed_cases[$];
  longint unsigned path_row[GRID_MAX];
  int unsigned     send_idle_pct = 15;
  int unsigned     recv_idle_pct = 85;
  int unsigned     requests_sent = 0;
  int unsigned     requests_rejected = 0;
  int unsigned     answers_checked = 0;
  int unsigned     mismatches = 0;
  int unsigned     idle_cycles = 0;

  checkpoint_lattice_path_power_mod_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count right/down paths through a rows x cols block with a single row buffer.
  function automatic logic [ANSWER_W-1:0] lattice_paths(input int unsigned rows,
                                                        input int unsigned cols);
    int unsigned i, j;
    for (j = 0; j < cols; j++) path_row[j] = 1;
    for (i = 1; i < rows; i++) begin
      for (j = 1; j < cols; j++) begin
        path_row[j] = (path_row[j] + path_row[j-1]) % PRIME;
      end
    end
    return ANSWER_W'(path_row[cols-1]);
  endfunction

  function automatic logic [ANSWER_W-1:0] mod_mul(input logic [ANSWER_W-1:0] a,
                                                  input logic [ANSWER_W-1:0] b);
    longint unsigned prod;
    prod = 64'(a) * 64'(b);
    return ANSWER_W'(prod % PRIME);
  endfunction

  // Expected result of one request: path product raised to the exponent.
  function automatic rsp_t paths_power(input req_t r);
    rsp_t              res;
    int unsigned       rows, cols, cr, cc;
    logic [ANSWER_W-1:0] base, acc;
    logic [EXP_W-1:0]  e;
    rows = r.grid_rows;
    cols = r.grid_cols;
    cr   = r.check_row;
    cc   = r.check_col;
    res  = '0;
    if (rows == 0 || cols == 0 || rows > GRID_MAX || cols > GRID_MAX ||
        cr == 0 || cc == 0 || cr > rows || cc > cols) begin
      res.bad_request = 1'b1;
      return res;
    end
    base = mod_mul(lattice_paths(cr, cc), lattice_paths(rows - cr + 1, cols - cc + 1));
    acc  = ANSWER_W'(1);
    e    = r.exponent;
    while (e != 0) begin
      if (e[0]) acc = mod_mul(acc, base);
      e    = e >> 1;
      base = mod_mul(base, base);
    end
    res.answer = acc;
    return res;
  endfunction

  function automatic void add_case(input int unsigned rows, input int unsigned cols,
                                   input int unsigned cr, input int unsigned cc,
                                   input logic [EXP_W-1:0] e, input bit typed,
                                   input int unsigned answer, input bit bad);
    path_case_t c;
    c.stim.grid_rows = FIELD_W'(rows);
    c.stim.grid_cols = FIELD_W'(cols);
    c.stim.check_row = FIELD_W'(cr);
    c.stim.check_col = FIELD_W'(cc);
    c.stim.exponent  = e;
    c.typed          = typed;
    c.want.answer    = ANSWER_W'(answer);
    c.want.bad_request = bad;
    directed_cases.insert(directed_cases.size(), c);
  endfunction

  // Offer one request with random gaps and record its expected result on acceptance.
  task automatic send_request(input req_t r, input bit typed, input rsp_t typed_rsp);
    rsp_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    want = typed ? typed_rsp : paths_power(r);
    if (want.bad_request) requests_rejected++;
    requests_sent++;
    pending_answers.insert(pending_answers.size(), want);
    @(negedge clk);
  endtask

  // Stop offering requests until every expected result has come back.
  task automatic hold_until_drained();
    req_valid <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic flag_mismatch(input string field, input longint unsigned want,
                               input longint unsigned got);
    if (mismatches < 10) begin
      $display("Mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, want, got);
    end
    mismatches++;
  endtask

  // Result side stalls at random on the falling edge.
  always @(negedge clk) begin
    rsp_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_answers.size() == 0) begin
        flag_mismatch("unexpected result answer", 0, rsp.answer);
      end else begin
        want = pending_answers.pop_front();
        answers_checked++;
        if (rsp.answer !== want.answer) flag_mismatch("answer", want.answer, rsp.answer);
        if (rsp.bad_request !== want.bad_request) begin
          flag_mismatch("bad_request", want.bad_request, rsp.bad_request);
        end
      end
    end
  end

  // Watchdog on cycles where neither channel moves a request or result.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // Stimulus: directed table first, then random requests in three idling phases.
  initial begin
    req_t        r;
    int unsigned n, shape, rows, cols, e_pick;

    // Trivial grids, extremes and rejected requests have answers known up front.
    add_case(1, 1, 1, 1, '0, 1'b1, 1, 1'b0);
    add_case(1, 1, 1, 1, EXP_MAX, 1'b1, 1, 1'b0);
    add_case(2, 2, 1, 1, 1, 1'b1, 2, 1'b0);
    add_case(2, 2, 2, 2, 1, 1'b1, 2, 1'b0);
    add_case(3, 3, 2, 2, 1, 1'b1, 4, 1'b0);
    add_case(10, 10, 5, 5, '0, 1'b1, 1, 1'b0);
    add_case(0, 5, 1, 1, 3, 1'b1, 0, 1'b1);
    add_case(5, 0, 1, 1, 3, 1'b1, 0, 1'b1);
    add_case(1025, 4, 1, 1, 3, 1'b1, 0, 1'b1);
    add_case(4, 2047, 1, 1, 3, 1'b1, 0, 1'b1);
    add_case(4, 4, 0, 2, 3, 1'b1, 0, 1'b1);
    add_case(4, 4, 2, 0, 3, 1'b1, 0, 1'b1);
    add_case(4, 4, 5, 2, EXP_MAX, 1'b1, 0, 1'b1);
    add_case(4, 4, 2, 2047, '0, 1'b1, 0, 1'b1);
    add_case(2047, 2047, 2047, 2047, EXP_MAX, 1'b1, 0, 1'b1);
    add_case(1024, 1, 1024, 1, EXP_MAX, 1'b1, 1, 1'b0);
    add_case(1, 1024, 1, 1024, 7, 1'b1, 1, 1'b0);
    add_case(1, 1024, 1, 512, 5, 1'b1, 1, 1'b0);
    // Larger grids go through the predictor.
    add_case(1024, 2, 1, 1, 12345, 1'b0, 0, 1'b0);
    add_case(1024, 3, 1024, 3, EXP_MAX, 1'b0, 0, 1'b0);
    add_case(20, 30, 7, 9, {1'b1, {(EXP_W-1){1'b0}}}, 1'b0, 0, 1'b0);
    add_case(64, 64, 64, 64, 3, 1'b0, 0, 1'b0);
    add_case(1024, 1024, 512, 512, 63'h2545_f491_4f6c_dd1d, 1'b0, 0, 1'b0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_cases[i]) begin
      send_request(directed_cases[i].stim, directed_cases[i].typed, directed_cases[i].want);
    end

    for (n = 0; n < 78; n++) begin
      if (n == 0 || n == 26 || n == 52) hold_until_drained();
      if (n == 26) begin
        send_idle_pct = 85;
        recv_idle_pct = 15;
      end else if (n == 52) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // Mostly small grids, some long thin ones, a few medium ones.
      shape = $urandom_range(99);
      if (shape < 70) begin
        rows = $urandom_range(16, 1);
        cols = $urandom_range(16, 1);
      end else if (shape < 85) begin
        rows = $urandom_range(GRID_MAX, 1);
        cols = $urandom_range(3, 1);
        if ($urandom_range(1)) {rows, cols} = {cols, rows};
      end else begin
        rows = $urandom_range(64, 1);
        cols = $urandom_range(64, 1);
      end
      r.grid_rows = FIELD_W'(rows);
      r.grid_cols = FIELD_W'(cols);
      r.check_row = FIELD_W'($urandom_range(rows, 1));
      r.check_col = FIELD_W'($urandom_range(cols, 1));

      e_pick = $urandom_range(9);
      if (e_pick == 0) r.exponent = '0;
      else if (e_pick < 4) r.exponent = EXP_W'($urandom_range(255));
      else r.exponent = EXP_W'({$urandom(), $urandom()});

      // Break about one request in seven.
      if ($urandom_range(99) < 15) begin
        case ($urandom_range(6))
          0: r.grid_rows = '0;
          1: r.grid_cols = FIELD_W'($urandom_range(2047, GRID_MAX + 1));
          2: r.check_row = '0;
          3: r.check_col = '0;
          4: r.check_row = FIELD_W'($urandom_range(2047, rows + 1));
          5: r.check_col = FIELD_W'($urandom_range(2047, cols + 1));
          default: r.grid_rows = FIELD_W'($urandom_range(2047, GRID_MAX + 1));
        endcase
      end
      send_request(r, 1'b0, '0);
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Checked %0d results from %0d requests, %0d of them rejected.",
             answers_checked, requests_sent, requests_rejected);
    $display("Grids ran from 1x1 to 1024x1024 under sender, receiver and no-gap idling.");
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("Total mismatches: %0d", mismatches);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> checkpoint_lattice_path_power_mod_unit.f
src/cplpm_pkg.sv
src/cplpm_ram.sv
src/cplpm_mulmod.sv
src/checkpoint_lattice_path_power_mod_unit.sv
dv/checkpoint_lattice_path_power_mod_unit_test.sv
